// ===== src/ptbn_pkg.sv =====
// Shared types, constants and command codes for the pair turnover likelihood block.
`timescale 1ns / 1ps
package ptbn_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int SITE_COUNT = 4096;
	localparam int SITE_AW    = $clog2(SITE_COUNT);
	localparam int COEF_COUNT = 16;
	localparam int COEF_AW    = (COEF_COUNT > 1) ? $clog2(COEF_COUNT) : 1;
	localparam int ELEM_CW    = $clog2(COEF_COUNT + 1);

	localparam int EXP_HALVINGS = 10;
	localparam int LOG_BITS     = 20;
	localparam int DIV_W        = 16 + FRAC_BITS + 16;
	localparam int LN_SHL       = (FRAC_BITS >= LOG_BITS) ? FRAC_BITS - LOG_BITS : 0;
	localparam int LN_SHR       = (FRAC_BITS < LOG_BITS) ? LOG_BITS - FRAC_BITS : 0;
	localparam int STEP_W       = 6;

	localparam logic [47:0] MAX48   = 48'hFFFF_FFFF_FFFF;
	localparam logic [31:0] Q30_ONE = 32'h4000_0000;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [15:0] P_MIN   = 16'd1;
	localparam logic [15:0] P_MAX   = 16'd65534;

	localparam logic [STEP_W-1:0] SQ_STEPS  = STEP_W'(EXP_HALVINGS);
	localparam logic [STEP_W-1:0] LOG_STEPS = STEP_W'(LOG_BITS);
	localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(DIV_W);

	typedef enum logic [1:0] {
		OPC_RICH  = 2'd0,
		OPC_COEF  = 2'd1,
		OPC_PAIR  = 2'd2,
		OPC_CLEAR = 2'd3
	} opc_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_ACC, ST_ETA, ST_RED, ST_R2, ST_R3, ST_POLY, ST_SQ, ST_SIM,
		ST_DIVA_LD, ST_DIVA, ST_DIVB_LD, ST_DIVB, ST_PROB, ST_NORM, ST_LOGSQ,
		ST_LN, ST_WTERM, ST_ADD, ST_OUT
	} state_t;

	typedef enum logic [4:0] {
		DP_NONE, DP_ACCEPT, DP_ACC, DP_ETA, DP_RED, DP_R2, DP_R3, DP_POLY, DP_SQ,
		DP_SIM, DP_DIV_A, DP_DIV_B, DP_DIV_STEP, DP_PROB, DP_NORM, DP_LOGSQ,
		DP_LN, DP_WTERM, DP_ADD, DP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   out_load;
	} cmd_t;

endpackage

// ===== src/ptbn_item_if.sv =====
// Input item channel: valid, ready and the item payload.
`timescale 1ns / 1ps
interface ptbn_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [11:0] table_index;
	logic [31:0] value;
	logic [11:0] site_first;
	logic [11:0] site_second;
	logic        mismatch;
	logic [31:0] weight;
	logic        last_element;

	modport source (output valid, opcode, table_index, value, site_first, site_second,
		mismatch, weight, last_element, input ready);
	modport sink (input valid, opcode, table_index, value, site_first, site_second,
		mismatch, weight, last_element, output ready);
endinterface

// ===== src/ptbn_result_if.sv =====
// Result item channel: valid, ready and the result payload.
`timescale 1ns / 1ps
interface ptbn_result_if;
	logic        valid;
	logic        ready;
	logic [47:0] linear_predictor;
	logic [15:0] similarity;
	logic [15:0] match_probability;
	logic [47:0] running_loss;

	modport source (output valid, linear_predictor, similarity, match_probability,
		running_loss, input ready);
	modport sink (input valid, linear_predictor, similarity, match_probability,
		running_loss, output ready);
endinterface

// ===== src/ptbn_cfg_if.sv =====
// Configuration write channel carrying the intercept register.
`timescale 1ns / 1ps
interface ptbn_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== src/pair_turnover_bernoulli_nll.sv =====
// Top level of the pair turnover Bernoulli negative log-likelihood accumulator.
`timescale 1ns / 1ps
//
//  Channel     Role   Moves
//  item_in     sink   one load, clear or pair covariate element item
//  result_out  source eta, similarity, probability and running loss of a pair
//  cfg         sink   a write of the intercept register (always ready)
//
// A load or clear item is only accepted; a covariate element that is not the last
// is accepted, then accumulated. The last element of a pair also runs the tail,
// mostly the two 48-step restoring divisions of the probability on one shared
// subtractor and the 20 squaring steps of the log on one multiplier. Reset clears
// the state machine, the accumulators, the element counter and the intercept; the
// tables are undefined until loaded. A waiting result stops only the next result
// from loading, but that stall holds the controller, so no item is then accepted.
module pair_turnover_bernoulli_nll (
	input logic           clk,
	input logic           arst_n,
	ptbn_item_if.sink     item_in,
	ptbn_result_if.source result_out,
	ptbn_cfg_if.sink      cfg
);

	ptbn_pkg::cmd_t cmd;

	// The intercept register takes every write at once.
	assign cfg.ready = 1'b1;

	// Walks each item through the datapath, one step per cycle unless stalled.
	ptbn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_in.valid),
		.in_opcode (item_in.opcode),
		.in_last   (item_in.last_element),
		.in_ready  (item_in.ready),
		.out_ready (result_out.ready),
		.out_valid (result_out.valid),
		.cmd       (cmd)
	);

	// The datapath holds the tables, the running sums and the result register.
	ptbn_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.opcode            (item_in.opcode),
		.table_index       (item_in.table_index),
		.value             (item_in.value),
		.site_first        (item_in.site_first),
		.site_second       (item_in.site_second),
		.mismatch          (item_in.mismatch),
		.weight            (item_in.weight),
		.cfg_we            (cfg.valid),
		.cfg_data          (cfg.data),
		.linear_predictor  (result_out.linear_predictor),
		.similarity        (result_out.similarity),
		.match_probability (result_out.match_probability),
		.running_loss      (result_out.running_loss)
	);

endmodule

// ===== src/ptbn_dp.sv =====
// Datapath: tables, accumulators, exp, divider, log and the result register.
`timescale 1ns / 1ps
module ptbn_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  ptbn_pkg::cmd_t      cmd,
	input  logic [1:0]          opcode,
	input  logic [11:0]         table_index,
	input  logic [31:0]         value,
	input  logic [11:0]         site_first,
	input  logic [11:0]         site_second,
	input  logic                mismatch,
	input  logic [31:0]         weight,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_data,
	output logic [47:0]         linear_predictor,
	output logic [15:0]         similarity,
	output logic [15:0]         match_probability,
	output logic [47:0]         running_loss
);

	localparam int DIV_WL = ptbn_pkg::DIV_W;

	logic [31:0] rich_mem [ptbn_pkg::SITE_COUNT];
	logic [31:0] coef_q [ptbn_pkg::COEF_COUNT];
	logic [31:0] mem_rd_q;
	logic [ptbn_pkg::SITE_AW-1:0] rd_addr;

	logic [31:0] intercept_q;
	logic [ptbn_pkg::ELEM_CW-1:0] elem_cnt_q;
	logic [47:0] pp_q;
	logic [47:0] loss_q;

	logic [63:0] prod_q;
	logic [ptbn_pkg::SITE_AW-1:0] sa_q, sb_q;
	logic        mis_q;
	logic [31:0] w_q;
	logic [47:0] eta_q;
	logic        big_q;
	logic [31:0] r_q, r2_q, r3_q, e_q;
	logic [31:0] rich_a_q, rich_b_q;
	logic [15:0] s_q;
	logic [DIV_WL-1:0] num_q, quo_q, ta_q;
	logic [33:0] rem_q;
	logic [32:0] den_q;
	logic [15:0] p_q, q_q;
	logic [3:0]  m_q;
	logic [30:0] z_q;
	logic [19:0] frac_q;
	logic [24:0] ln20_q;
	logic [47:0] term_q;
	logic [47:0] out_eta_q, out_loss_q;
	logic [15:0] out_s_q, out_p_q;

	logic        is_acc;
	logic [48:0] pp_sum, eta_sum, loss_sum;
	logic [63:0] sq_prod, r2_prod, r3_prod, ln_prod, w_prod;
	logic [63:0] z_prod;
	logic [31:0] z_sq;
	logic [32:0] r3_div6;
	logic [31:0] poly;
	logic [17:0] s_round;
	logic [33:0] rem_sh;
	logic [49:0] p_sum;
	logic [33:0] p_raw;
	logic [15:0] p_clamp;
	logic [3:0]  msb;
	logic [24:0] nl2;
	logic [31:0] ln_f;

	assign is_acc  = (cmd.op == ptbn_pkg::DP_ACCEPT);
	assign rd_addr = (cmd.op == ptbn_pkg::DP_ETA) ? sa_q : sb_q;

	// Rich table: written on rich load items, read one site per cycle.
	always_ff @(posedge clk) begin
		if (is_acc && opcode == ptbn_pkg::OPC_RICH) begin
			rich_mem[table_index[ptbn_pkg::SITE_AW-1:0]] <= value;
		end
		mem_rd_q <= rich_mem[rd_addr];
	end

	always_comb begin
		pp_sum   = {1'b0, pp_q} + {1'b0, prod_q[ptbn_pkg::FRAC_BITS +: 48]};
		eta_sum  = {1'b0, pp_q} + 49'(intercept_q);
		loss_sum = {1'b0, loss_q} + {1'b0, term_q};
		r2_prod  = 64'(r_q) * 64'(r_q);
		r3_prod  = 64'(r2_q) * 64'(r_q);
		r3_div6  = (33'(r3_q[15:0]) * 33'd43691) >> 18;
		poly     = ptbn_pkg::Q30_ONE - r_q + (r2_q >> 1) - r3_div6[31:0];
		sq_prod  = 64'(e_q) * 64'(e_q) + 64'(ptbn_pkg::Q30_ONE >> 1);
		s_round  = 18'((e_q + 32'd8192) >> 14);
		rem_sh   = {rem_q[32:0], num_q[DIV_WL-1]};
		p_sum    = 50'(ta_q) + 50'(quo_q) + 50'd32768;
		p_raw    = p_sum[49:16];
		if ((rich_a_q == 32'd0) || (rich_b_q == 32'd0)) begin
			p_clamp = ptbn_pkg::P_MAX;
		end else if (p_raw < 34'(ptbn_pkg::P_MIN)) begin
			p_clamp = ptbn_pkg::P_MIN;
		end else if (p_raw > 34'(ptbn_pkg::P_MAX)) begin
			p_clamp = ptbn_pkg::P_MAX;
		end else begin
			p_clamp = p_raw[15:0];
		end
		msb = 4'd0;
		for (int i = 1; i < 16; i++) begin
			if (q_q[i]) begin
				msb = 4'(i);
			end
		end
		z_prod  = 64'(z_q) * 64'(z_q);
		z_sq    = z_prod[61:30];
		nl2     = (25'(5'd16 - 5'(m_q)) << ptbn_pkg::LOG_BITS) - 25'(frac_q);
		ln_prod = 64'(nl2) * 64'(ptbn_pkg::LN2_Q30);
		ln_f    = 32'((57'(ln20_q) << ptbn_pkg::LN_SHL) >> ptbn_pkg::LN_SHR);
		w_prod  = 64'(w_q) * 64'(ln_f);
	end

	// Control state: register, accumulators, element counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intercept_q <= '0;
			elem_cnt_q  <= '0;
			pp_q        <= '0;
			loss_q      <= '0;
		end else begin
			if (cfg_we) begin
				intercept_q <= cfg_data;
			end
			if (is_acc && opcode == ptbn_pkg::OPC_CLEAR) begin
				loss_q <= '0;
			end
			if (cmd.op == ptbn_pkg::DP_ACC &&
			    elem_cnt_q < ptbn_pkg::ELEM_CW'(ptbn_pkg::COEF_COUNT)) begin
				pp_q       <= pp_sum[48] ? ptbn_pkg::MAX48 : pp_sum[47:0];
				elem_cnt_q <= elem_cnt_q + 1'b1;
			end
			if (cmd.op == ptbn_pkg::DP_ETA) begin
				pp_q       <= '0;
				elem_cnt_q <= '0;
			end
			if (cmd.op == ptbn_pkg::DP_ADD) begin
				loss_q <= loss_sum[48] ? ptbn_pkg::MAX48 : loss_sum[47:0];
			end
		end
	end

	// Payload registers of the arithmetic tail.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ptbn_pkg::DP_ACCEPT: begin
				if (opcode == ptbn_pkg::OPC_COEF &&
				    table_index < 12'(ptbn_pkg::COEF_COUNT)) begin
					coef_q[table_index[ptbn_pkg::COEF_AW-1:0]] <= value;
				end
				prod_q <= 64'(value) * 64'(coef_q[elem_cnt_q[ptbn_pkg::COEF_AW-1:0]]);
				sa_q   <= site_first[ptbn_pkg::SITE_AW-1:0];
				sb_q   <= site_second[ptbn_pkg::SITE_AW-1:0];
				mis_q  <= mismatch;
				w_q    <= weight;
			end
			ptbn_pkg::DP_ETA: begin
				eta_q <= eta_sum[48] ? ptbn_pkg::MAX48 : eta_sum[47:0];
			end
			ptbn_pkg::DP_RED: begin
				big_q    <= eta_q >= (48'd12 << ptbn_pkg::FRAC_BITS);
				r_q      <= 32'((64'(eta_q) << (30 - ptbn_pkg::FRAC_BITS))
					>> ptbn_pkg::EXP_HALVINGS);
				rich_a_q <= mem_rd_q;
			end
			ptbn_pkg::DP_R2: begin
				r2_q     <= r2_prod[61:30];
				rich_b_q <= mem_rd_q;
			end
			ptbn_pkg::DP_R3: r3_q <= r3_prod[61:30];
			ptbn_pkg::DP_POLY: e_q <= poly;
			ptbn_pkg::DP_SQ: e_q <= sq_prod[61:30];
			ptbn_pkg::DP_SIM: begin
				if (big_q) begin
					s_q <= 16'd0;
				end else if (s_round > 18'd65535) begin
					s_q <= 16'hFFFF;
				end else begin
					s_q <= s_round[15:0];
				end
			end
			ptbn_pkg::DP_DIV_A: begin
				num_q <= DIV_WL'(s_q) << (ptbn_pkg::FRAC_BITS + 16);
				rem_q <= '0;
				den_q <= {rich_a_q, 1'b0};
			end
			ptbn_pkg::DP_DIV_B: begin
				ta_q  <= quo_q;
				num_q <= DIV_WL'(s_q) << (ptbn_pkg::FRAC_BITS + 16);
				rem_q <= '0;
				den_q <= {rich_b_q, 1'b0};
			end
			ptbn_pkg::DP_DIV_STEP: begin
				num_q <= num_q << 1;
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q <= rem_sh - {1'b0, den_q};
					quo_q <= {quo_q[DIV_WL-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[DIV_WL-2:0], 1'b0};
				end
			end
			ptbn_pkg::DP_PROB: begin
				p_q <= p_clamp;
				q_q <= mis_q ? 16'(17'h10000 - 17'(p_clamp)) : p_clamp;
			end
			ptbn_pkg::DP_NORM: begin
				m_q    <= msb;
				z_q    <= 31'(q_q) << (5'd30 - 5'(msb));
				frac_q <= '0;
			end
			ptbn_pkg::DP_LOGSQ: begin
				if (z_sq >= 32'h8000_0000) begin
					frac_q <= {frac_q[18:0], 1'b1};
					z_q    <= z_sq[31:1];
				end else begin
					frac_q <= {frac_q[18:0], 1'b0};
					z_q    <= z_sq[30:0];
				end
			end
			ptbn_pkg::DP_LN: ln20_q <= ln_prod[54:30];
			ptbn_pkg::DP_WTERM: term_q <= w_prod[ptbn_pkg::FRAC_BITS +: 48];
			ptbn_pkg::DP_OUT: begin
				out_eta_q  <= eta_q;
				out_s_q    <= s_q;
				out_p_q    <= p_q;
				out_loss_q <= loss_q;
			end
			default: begin
			end
		endcase
	end

	assign linear_predictor  = out_eta_q;
	assign similarity        = out_s_q;
	assign match_probability = out_p_q;
	assign running_loss      = out_loss_q;

endmodule

// ===== src/ptbn_ctrl.sv =====
// Controller: sequences each item through the datapath and owns the handshakes.
`timescale 1ns / 1ps
module ptbn_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     in_opcode,
	input  logic           in_last,
	output logic           in_ready,
	input  logic           out_ready,
	output logic           out_valid,
	output ptbn_pkg::cmd_t cmd
);

	ptbn_pkg::state_t state_q, state_d;
	logic [ptbn_pkg::STEP_W-1:0] step_q;
	logic last_q;
	logic out_valid_q;
	logic accept;
	logic slot_free;

	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptbn_pkg::ST_IDLE: begin
				if (in_valid && in_opcode == ptbn_pkg::OPC_PAIR) begin
					state_d = ptbn_pkg::ST_ACC;
				end
			end
			ptbn_pkg::ST_ACC: state_d = last_q ? ptbn_pkg::ST_ETA : ptbn_pkg::ST_IDLE;
			ptbn_pkg::ST_ETA: state_d = ptbn_pkg::ST_RED;
			ptbn_pkg::ST_RED: state_d = ptbn_pkg::ST_R2;
			ptbn_pkg::ST_R2: state_d = ptbn_pkg::ST_R3;
			ptbn_pkg::ST_R3: state_d = ptbn_pkg::ST_POLY;
			ptbn_pkg::ST_POLY: state_d = ptbn_pkg::ST_SQ;
			ptbn_pkg::ST_SQ: begin
				if (step_q == ptbn_pkg::SQ_STEPS - 1'b1) begin
					state_d = ptbn_pkg::ST_SIM;
				end
			end
			ptbn_pkg::ST_SIM: state_d = ptbn_pkg::ST_DIVA_LD;
			ptbn_pkg::ST_DIVA_LD: state_d = ptbn_pkg::ST_DIVA;
			ptbn_pkg::ST_DIVA: begin
				if (step_q == ptbn_pkg::DIV_STEPS - 1'b1) begin
					state_d = ptbn_pkg::ST_DIVB_LD;
				end
			end
			ptbn_pkg::ST_DIVB_LD: state_d = ptbn_pkg::ST_DIVB;
			ptbn_pkg::ST_DIVB: begin
				if (step_q == ptbn_pkg::DIV_STEPS - 1'b1) begin
					state_d = ptbn_pkg::ST_PROB;
				end
			end
			ptbn_pkg::ST_PROB: state_d = ptbn_pkg::ST_NORM;
			ptbn_pkg::ST_NORM: state_d = ptbn_pkg::ST_LOGSQ;
			ptbn_pkg::ST_LOGSQ: begin
				if (step_q == ptbn_pkg::LOG_STEPS - 1'b1) begin
					state_d = ptbn_pkg::ST_LN;
				end
			end
			ptbn_pkg::ST_LN: state_d = ptbn_pkg::ST_WTERM;
			ptbn_pkg::ST_WTERM: state_d = ptbn_pkg::ST_ADD;
			ptbn_pkg::ST_ADD: state_d = ptbn_pkg::ST_OUT;
			ptbn_pkg::ST_OUT: begin
				if (slot_free) begin
					state_d = ptbn_pkg::ST_IDLE;
				end
			end
			default: state_d = ptbn_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd.op       = ptbn_pkg::DP_NONE;
		cmd.out_load = 1'b0;
		unique case (state_q)
			ptbn_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = ptbn_pkg::DP_ACCEPT;
				end
			end
			ptbn_pkg::ST_ACC: cmd.op = ptbn_pkg::DP_ACC;
			ptbn_pkg::ST_ETA: cmd.op = ptbn_pkg::DP_ETA;
			ptbn_pkg::ST_RED: cmd.op = ptbn_pkg::DP_RED;
			ptbn_pkg::ST_R2: cmd.op = ptbn_pkg::DP_R2;
			ptbn_pkg::ST_R3: cmd.op = ptbn_pkg::DP_R3;
			ptbn_pkg::ST_POLY: cmd.op = ptbn_pkg::DP_POLY;
			ptbn_pkg::ST_SQ: cmd.op = ptbn_pkg::DP_SQ;
			ptbn_pkg::ST_SIM: cmd.op = ptbn_pkg::DP_SIM;
			ptbn_pkg::ST_DIVA_LD: cmd.op = ptbn_pkg::DP_DIV_A;
			ptbn_pkg::ST_DIVA: cmd.op = ptbn_pkg::DP_DIV_STEP;
			ptbn_pkg::ST_DIVB_LD: cmd.op = ptbn_pkg::DP_DIV_B;
			ptbn_pkg::ST_DIVB: cmd.op = ptbn_pkg::DP_DIV_STEP;
			ptbn_pkg::ST_PROB: cmd.op = ptbn_pkg::DP_PROB;
			ptbn_pkg::ST_NORM: cmd.op = ptbn_pkg::DP_NORM;
			ptbn_pkg::ST_LOGSQ: cmd.op = ptbn_pkg::DP_LOGSQ;
			ptbn_pkg::ST_LN: cmd.op = ptbn_pkg::DP_LN;
			ptbn_pkg::ST_WTERM: cmd.op = ptbn_pkg::DP_WTERM;
			ptbn_pkg::ST_ADD: cmd.op = ptbn_pkg::DP_ADD;
			ptbn_pkg::ST_OUT: begin
				if (slot_free) begin
					cmd.op       = ptbn_pkg::DP_OUT;
					cmd.out_load = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptbn_pkg::ST_IDLE;
			step_q      <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_d != state_q) ? '0 : step_q + 1'b1;
			if (accept) begin
				last_q <= in_last;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_load_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> state_q == ptbn_pkg::ST_IDLE)
		else $error("result load did not return to idle");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while waiting");
	a_pair_to_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_opcode == ptbn_pkg::OPC_PAIR) |=> state_q == ptbn_pkg::ST_ACC)
		else $error("pair element not accumulated");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ptbn_pkg::ST_DIVA || state_q == ptbn_pkg::ST_DIVB)
		|-> step_q < ptbn_pkg::DIV_STEPS)
		else $error("divider ran past its step count");

endmodule
